// ===== hdl/priority_aging_tick_scheduler_core_macros.svh =====
// Assertion macros for the priority aging tick scheduler.
// Included by the top level; expects clk and rst_n in scope.
`ifndef PRIORITY_AGING_TICK_SCHEDULER_CORE_MACROS_SVH
`define PRIORITY_AGING_TICK_SCHEDULER_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PATS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scheduler assertion failed");

// Next-cycle implication, checked outside reset.
`define PATS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scheduler assertion failed");

`endif

// ===== hdl/pats_pkg.sv =====
// Shared types and constants of the priority aging tick scheduler.
// No dependencies.
package pats_pkg;

  localparam int        EIU_W      = 5;
  localparam logic [4:0] EIU_RESET = 5'd16;
  localparam logic [2:0] PRIO_LIMIT = 3'd6;
  localparam logic [2:0] PRIO_FLOOR = 3'd1;
  localparam logic [15:0] TIME_MAX  = 16'hFFFF;
  localparam logic [4:0] TOTAL_MAX  = 5'd31;
  localparam logic       KIND_LOAD  = 1'b0;
  localparam logic       KIND_TICK  = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [3:0]  entry_index;
    logic [15:0] arrival_time;
    logic [7:0]  run_time;
    logic [2:0]  start_priority;
  } pats_in_t;

  typedef struct packed {
    logic [15:0] tick_time;
    logic        busy_res;
    logic [3:0]  chosen_index;
    logic        finished_now;
    logic        all_done;
  } pats_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CHARGE
  } pats_state_t;

  typedef struct packed {
    logic idle;
    logic issue;
    logic eval;
    logic commit;
  } seq_ctl_t;

  typedef struct packed {
    logic arr;
    logic rem;
    logic pri;
  } mem_we_t;

endpackage

// ===== hdl/priority_aging_tick_scheduler_core.sv =====
// Priority aging tick scheduler: a table of tasks is loaded, and each tick picks
// the most urgent arrived task, charges it one unit and ages every unfinished
// entry in use. During a tick the sequencer reads one table entry per cycle
// through the single read port of the entry memories, over the effective
// number of entries in use, and passes it through the shared compare and aging
// unit, then charges the chosen entry once the output register is free. The
// result sits in an output register, so loads and the next tick are taken
// while it waits.
// Depends on pats_pkg, pats_seq, pats_unit, pats_store and the macro header.
`include "priority_aging_tick_scheduler_core_macros.svh"

module priority_aging_tick_scheduler_core #(
  parameter int NUM_ENTRIES = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  pats_pkg::pats_in_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output pats_pkg::pats_out_t             out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pats_pkg::EIU_W-1:0]      cfg_data
);
  import pats_pkg::*;

  localparam int IDX_W = $clog2(NUM_ENTRIES);
  localparam int CNT_W = $clog2(NUM_ENTRIES + 1);

  seq_ctl_t          ctl;
  logic [IDX_W-1:0]  rd_addr;
  logic [IDX_W-1:0]  eval_idx;
  logic [CNT_W-1:0]  n_eff;
  logic              commit_ok;

  logic [EIU_W-1:0]       eiu_r;
  logic [15:0]            time_r;
  logic [4:0]             total_r;
  logic [NUM_ENTRIES-1:0] fin_r;
  logic                   best_vld_r;
  logic [IDX_W-1:0]       best_idx_r;
  logic [2:0]             best_prio_r;
  logic [7:0]             best_rem_r;
  logic                   out_valid_r, out_valid_nxt;
  pats_out_t              out_data_r, out_data_nxt;

  logic              in_acc, start, load_ok;
  logic [IDX_W-1:0]  load_addr;
  logic [15:0]       rd_arrival;
  logic [7:0]        rd_remaining;
  logic [2:0]        rd_priority;
  logic              better;
  logic [2:0]        aged_prio;
  logic              fin_now;
  logic [7:0]        rem_charged;
  logic [4:0]        total_chg;
  mem_we_t           we;
  logic [IDX_W-1:0]  wr_addr;
  logic [7:0]        wr_remaining;
  logic [2:0]        wr_priority;

  assign in_ready  = ctl.idle;
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign start     = in_acc && (in_data.kind == KIND_TICK);
  assign load_ok   = in_acc && (in_data.kind == KIND_LOAD) &&
                     (32'(in_data.entry_index) < NUM_ENTRIES);
  assign load_addr = IDX_W'(in_data.entry_index);
  assign commit_ok = !out_valid_r || out_ready;

  always_comb begin
    if (eiu_r == '0) begin
      n_eff = CNT_W'(1);
    end else if (32'(eiu_r) > NUM_ENTRIES) begin
      n_eff = CNT_W'(NUM_ENTRIES);
    end else begin
      n_eff = CNT_W'(eiu_r);
    end
  end

  pats_seq #(.NUM_ENTRIES(NUM_ENTRIES)) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .n_eff      (n_eff),
    .commit_ok  (commit_ok),
    .ctl        (ctl),
    .rd_addr    (rd_addr),
    .eval_idx_r (eval_idx)
  );

  pats_unit u_unit (
    .arrival   (rd_arrival),
    .prio      (rd_priority),
    .finished  (fin_r[eval_idx]),
    .time_now  (time_r),
    .best_prio (best_prio_r),
    .better    (better),
    .aged_prio (aged_prio)
  );

  assign fin_now     = best_vld_r && (best_rem_r <= 8'd1);
  assign rem_charged = fin_now ? 8'd0 : (best_rem_r - 8'd1);
  assign total_chg   = (fin_now && (total_r != TOTAL_MAX)) ? (total_r + 5'd1) : total_r;

  always_comb begin
    we.arr = load_ok;
    we.rem = load_ok || (ctl.commit && best_vld_r);
    we.pri = load_ok || ctl.eval;
    if (load_ok) begin
      wr_addr      = load_addr;
      wr_remaining = in_data.run_time;
      wr_priority  = in_data.start_priority;
    end else if (ctl.eval) begin
      wr_addr      = eval_idx;
      wr_remaining = rem_charged;
      wr_priority  = aged_prio;
    end else begin
      wr_addr      = best_idx_r;
      wr_remaining = rem_charged;
      wr_priority  = aged_prio;
    end
  end

  pats_store #(.NUM_ENTRIES(NUM_ENTRIES)) u_store (
    .clk            (clk),
    .we             (we),
    .wr_addr        (wr_addr),
    .wr_arrival     (in_data.arrival_time),
    .wr_remaining   (wr_remaining),
    .wr_priority    (wr_priority),
    .rd_addr        (rd_addr),
    .rd_arrival_r   (rd_arrival),
    .rd_remaining_r (rd_remaining),
    .rd_priority_r  (rd_priority)
  );

  always_comb begin
    out_data_nxt.tick_time    = time_r;
    out_data_nxt.busy_res     = best_vld_r;
    out_data_nxt.chosen_index = best_vld_r ? 4'(best_idx_r) : 4'd0;
    out_data_nxt.finished_now = fin_now;
    out_data_nxt.all_done     = (32'(total_chg) == 32'(n_eff));
    if (ctl.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eiu_r       <= EIU_RESET;
      time_r      <= '0;
      total_r     <= '0;
      fin_r       <= '0;
      best_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        eiu_r <= cfg_data;
      end
      if (load_ok) begin
        if (fin_r[load_addr] && (total_r != 5'd0)) begin
          total_r <= total_r - 5'd1;
        end
        fin_r[load_addr] <= 1'b0;
      end
      if (start) begin
        best_vld_r <= 1'b0;
      end else if (ctl.eval && better) begin
        best_vld_r <= 1'b1;
      end
      if (ctl.commit) begin
        if (fin_now) begin
          fin_r[best_idx_r] <= 1'b1;
        end
        total_r <= total_chg;
        if (time_r != TIME_MAX) begin
          time_r <= time_r + 16'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      best_prio_r <= PRIO_LIMIT;
    end else if (ctl.eval && better) begin
      best_prio_r <= rd_priority;
      best_idx_r  <= eval_idx;
      best_rem_r  <= rd_remaining;
    end
    if (ctl.commit) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `PATS_ASSERT_NXT(a_tick_blocks_input, in_valid && in_ready && (in_data.kind == KIND_TICK), !in_ready)
  `PATS_ASSERT_NXT(a_commit_posts_result, ctl.commit, out_valid)
  `PATS_ASSERT_IMP(a_idle_result_clean, out_valid && !out_data.busy_res, (out_data.chosen_index == 4'd0) && !out_data.finished_now)

endmodule

// ===== hdl/pats_store.sv =====
// Entry table memories: arrival time, remaining time and priority.
// One write port and one registered read port each; uses pats_pkg.
module pats_store #(
  parameter int  NUM_ENTRIES = 16,
  localparam int IDX_W       = $clog2(NUM_ENTRIES)
) (
  input  logic                 clk,
  input  pats_pkg::mem_we_t    we,
  input  logic [IDX_W-1:0]     wr_addr,
  input  logic [15:0]          wr_arrival,
  input  logic [7:0]           wr_remaining,
  input  logic [2:0]           wr_priority,
  input  logic [IDX_W-1:0]     rd_addr,
  output logic [15:0]          rd_arrival_r,
  output logic [7:0]           rd_remaining_r,
  output logic [2:0]           rd_priority_r
);
  import pats_pkg::*;

  logic [15:0] arrival_mem   [NUM_ENTRIES];
  logic [7:0]  remaining_mem [NUM_ENTRIES];
  logic [2:0]  priority_mem  [NUM_ENTRIES];

  always_ff @(posedge clk) begin
    if (we.arr) begin
      arrival_mem[wr_addr] <= wr_arrival;
    end
    rd_arrival_r <= arrival_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (we.rem) begin
      remaining_mem[wr_addr] <= wr_remaining;
    end
    rd_remaining_r <= remaining_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (we.pri) begin
      priority_mem[wr_addr] <= wr_priority;
    end
    rd_priority_r <= priority_mem[rd_addr];
  end

endmodule

// ===== hdl/pats_unit.sv =====
// Shared per-entry unit: eligibility and priority compare, and aging.
// Used once per scanned entry; uses pats_pkg.
module pats_unit (
  input  logic [15:0] arrival,
  input  logic [2:0]  prio,
  input  logic        finished,
  input  logic [15:0] time_now,
  input  logic [2:0]  best_prio,
  output logic        better,
  output logic [2:0]  aged_prio
);
  import pats_pkg::*;

  assign better    = !finished && (arrival <= time_now) && (prio < best_prio);
  assign aged_prio = (!finished && (prio > PRIO_FLOOR)) ? (prio - 3'd1) : prio;

endmodule

// ===== hdl/pats_seq.sv =====
// Sequencer: walks the table one entry per cycle for each tick.
// Produces read addresses and phase strobes; uses pats_pkg.
module pats_seq #(
  parameter int  NUM_ENTRIES = 16,
  localparam int IDX_W       = $clog2(NUM_ENTRIES),
  localparam int CNT_W       = $clog2(NUM_ENTRIES + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [CNT_W-1:0]    n_eff,
  input  logic                commit_ok,
  output pats_pkg::seq_ctl_t  ctl,
  output logic [IDX_W-1:0]    rd_addr,
  output logic [IDX_W-1:0]    eval_idx_r
);
  import pats_pkg::*;

  pats_state_t      state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             rd_vld_r, rd_vld_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      cnt_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      rd_vld_r <= rd_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    eval_idx_r <= rd_addr;
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (start) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cnt_r == n_eff) begin
          state_nxt = ST_CHARGE;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      ST_CHARGE: begin
        if (commit_ok) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ctl.idle   = 1'b0;
    ctl.issue  = 1'b0;
    ctl.commit = 1'b0;
    case (state_r)
      ST_IDLE: begin
        ctl.idle = 1'b1;
      end
      ST_SCAN: begin
        ctl.issue = (cnt_r != n_eff);
      end
      ST_CHARGE: begin
        ctl.commit = commit_ok;
      end
      default: begin
        ctl.idle = 1'b0;
      end
    endcase
    ctl.eval = rd_vld_r;
  end

  assign rd_vld_nxt = ctl.issue;
  assign rd_addr    = cnt_r[IDX_W-1:0];

endmodule

// ===== sim/pats_tick_checker.sv =====
// Checker for the priority aging tick scheduler: it keeps its own copy of the task
// table, predicts the result of every accepted tick and compares it with each
// result transfer. Depends on pats_pkg.
module pats_tick_checker #(
  parameter int NUM_ENTRIES = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  pats_pkg::pats_in_t         in_data,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  pats_pkg::pats_out_t        out_data,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [pats_pkg::EIU_W-1:0] cfg_data,
  output int                         fail_count,
  output int                         pending_count,
  output int                         results_checked,
  output int                         completions,
  output int                         all_done_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import pats_pkg::*;

  logic [15:0]      arrival_tbl   [NUM_ENTRIES];
  logic [7:0]       remaining_tbl [NUM_ENTRIES];
  logic [2:0]       prio_tbl      [NUM_ENTRIES];
  logic             finished_tbl  [NUM_ENTRIES];
  logic [15:0]      sched_time;
  logic [4:0]       finished_sum;
  logic [EIU_W-1:0] entries_in_use;
  pats_out_t        expected_ticks [$];

  function automatic pats_out_t schedule_tick();
    int        slots;
    int        best;
    int        best_prio;
    logic      done_now;
    pats_out_t res;
    slots = int'(entries_in_use);
    if (slots < 1) slots = 1;
    if (slots > NUM_ENTRIES) slots = NUM_ENTRIES;
    best = -1;
    best_prio = int'(PRIO_LIMIT);
    done_now = 1'b0;
    for (int i = 0; i < slots; i++) begin
      if (!finished_tbl[i] && arrival_tbl[i] <= sched_time && prio_tbl[i] < best_prio) begin
        best_prio = int'(prio_tbl[i]);
        best = i;
      end
    end
    if (best >= 0) begin
      if (remaining_tbl[best] <= 8'd1) begin
        remaining_tbl[best] = 8'd0;
        finished_tbl[best] = 1'b1;
        if (finished_sum < TOTAL_MAX) finished_sum++;
        done_now = 1'b1;
      end else begin
        remaining_tbl[best]--;
      end
    end
    for (int i = 0; i < slots; i++) begin
      if (!finished_tbl[i] && prio_tbl[i] > PRIO_FLOOR) prio_tbl[i]--;
    end
    res.tick_time = sched_time;
    res.busy_res = (best >= 0);
    res.chosen_index = (best >= 0) ? 4'(best) : 4'd0;
    res.finished_now = done_now;
    res.all_done = (finished_sum == slots);
    if (sched_time < TIME_MAX) sched_time++;
    return res;
  endfunction

  task automatic note_mismatch(input string what, input logic [15:0] expv,
                               input logic [15:0] actv);
    if (fail_count < 10) begin
      $display("%t: %s mismatch, expected %0h, got %0h", $realtime, what, expv, actv);
    end
    fail_count++;
  endtask

  always @(posedge clk) begin : watch
    pats_out_t want;
    if (!rst_n) begin
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        arrival_tbl[i] = '0;
        remaining_tbl[i] = '0;
        prio_tbl[i] = '0;
        finished_tbl[i] = 1'b0;
      end
      sched_time = '0;
      finished_sum = '0;
      entries_in_use = EIU_RESET;
      expected_ticks.delete();
      fail_count = 0;
      results_checked = 0;
      completions = 0;
      all_done_seen = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_ticks.size() == 0) begin
          if (fail_count < 10) begin
            $display("%t: result transfer with no tick outstanding", $realtime);
          end
          fail_count++;
        end else begin
          want = expected_ticks.pop_front();
          results_checked++;
          if (want.finished_now) completions++;
          if (want.all_done) all_done_seen++;
          if (out_data.tick_time !== want.tick_time) begin
            note_mismatch("tick_time", want.tick_time, out_data.tick_time);
          end
          if (out_data.busy_res !== want.busy_res) begin
            note_mismatch("busy_res", 16'(want.busy_res), 16'(out_data.busy_res));
          end
          if (out_data.chosen_index !== want.chosen_index) begin
            note_mismatch("chosen_index", 16'(want.chosen_index),
                          16'(out_data.chosen_index));
          end
          if (out_data.finished_now !== want.finished_now) begin
            note_mismatch("finished_now", 16'(want.finished_now),
                          16'(out_data.finished_now));
          end
          if (out_data.all_done !== want.all_done) begin
            note_mismatch("all_done", 16'(want.all_done), 16'(out_data.all_done));
          end
        end
      end
      if (in_valid && in_ready) begin
        if (in_data.kind == KIND_TICK) begin
          expected_ticks.push_back(schedule_tick());
        end else if (in_data.entry_index < NUM_ENTRIES) begin
          arrival_tbl[in_data.entry_index] = in_data.arrival_time;
          remaining_tbl[in_data.entry_index] = in_data.run_time;
          prio_tbl[in_data.entry_index] = in_data.start_priority;
          if (finished_tbl[in_data.entry_index] && finished_sum > 0) finished_sum--;
          finished_tbl[in_data.entry_index] = 1'b0;
        end
      end
      if (cfg_valid && cfg_ready) entries_in_use = cfg_data;
    end
    pending_count = expected_ticks.size();
  end

endmodule

// ===== sim/priority_aging_tick_scheduler_core_tb.sv =====
// Testbench top for the priority aging tick scheduler core: drives load, tick and
// configuration transfers with random idling and gives the verdict.
// Depends on pats_pkg, pats_tick_checker and the scheduler RTL.
module priority_aging_tick_scheduler_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pats_pkg::*;

  localparam int NUM_ENTRIES      = 16;
  localparam int CLK_PERIOD       = 20;
  localparam int SETTLE_CYCLES    = 40;
  localparam int RANDOM_ITEMS     = 1040;
  localparam int HOLD_AFTER_ITEMS = 400;
  localparam int LONG_HOLD_CYCLES = 600;
  localparam int FINAL_TICKS      = 40;
  localparam int CYCLE_LIMIT      = 500000;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  pats_in_t         in_data   = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  pats_out_t        out_data;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [EIU_W-1:0] cfg_data  = '0;

  int fail_count;
  int pending_count;
  int results_checked;
  int completions;
  int all_done_seen;

  int items_sent = 0;
  int ticks_sent = 0;
  int cycles     = 0;
  bit idle_on    = 1'b0;
  bit long_hold  = 1'b0;
  bit hold_done  = 1'b0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  priority_aging_tick_scheduler_core #(
    .NUM_ENTRIES(NUM_ENTRIES)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  pats_tick_checker #(
    .NUM_ENTRIES(NUM_ENTRIES)
  ) tick_check (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .fail_count(fail_count),
    .pending_count(pending_count),
    .results_checked(results_checked),
    .completions(completions),
    .all_done_seen(all_done_seen)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic [15:0] time_now();
    if (ticks_sent > 65535) return 16'hFFFF;
    return ticks_sent[15:0];
  endfunction

  task automatic send_item(input pats_in_t item);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (item.kind == KIND_TICK) ticks_sent++;
  endtask

  task automatic load_entry(input logic [3:0] slot, input logic [15:0] arrival,
                            input logic [7:0] run, input logic [2:0] prio);
    pats_in_t item;
    item.kind = KIND_LOAD;
    item.entry_index = slot;
    item.arrival_time = arrival;
    item.run_time = run;
    item.start_priority = prio;
    send_item(item);
  endtask

  task automatic tick_once();
    pats_in_t item;
    item = pats_in_t'($urandom);
    item.kind = KIND_TICK;
    send_item(item);
  endtask

  task automatic noise_load();
    pats_in_t item;
    item = pats_in_t'($urandom);
    item.kind = KIND_LOAD;
    send_item(item);
  endtask

  task automatic write_entries_in_use(input logic [EIU_W-1:0] value);
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending_count == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin : result_sink
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
        long_hold = 1'b0;
        out_ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    logic [EIU_W-1:0] eiu_value;
    int               slots;
    int               budget;
    int               arr;
    int               run;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part: extremes of every field, zero run time, priorities zero,
    // six and seven, tasks that never arrive, then a reload of a finished slot.
    idle_on = 1'b1;
    load_entry(4'd0, 16'd0, 8'd0, 3'd0);
    load_entry(4'd1, 16'd0, 8'd1, 3'd5);
    load_entry(4'd2, 16'd2, 8'd2, 3'd6);
    load_entry(4'd3, 16'd1, 8'd3, 3'd1);
    load_entry(4'd4, 16'd0, 8'd2, 3'd7);
    for (int i = 5; i < NUM_ENTRIES; i++) begin
      load_entry(4'(i), 16'hFFFF, 8'hFF, 3'(i));
    end
    repeat (8) tick_once();
    load_entry(4'd0, 16'd3, 8'd1, 3'd2);

    while (items_sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 7))
        0: eiu_value = 5'd0;
        1: eiu_value = 5'($urandom_range(17, 31));
        2: eiu_value = 5'd16;
        3: eiu_value = 5'd1;
        default: eiu_value = 5'($urandom_range(1, 16));
      endcase
      slots = (eiu_value == 0) ? 1 : ((eiu_value > NUM_ENTRIES) ? NUM_ENTRIES : eiu_value);
      write_entries_in_use(eiu_value);
      idle_on = ($urandom_range(0, 3) != 0);
      budget = 12;
      for (int i = 0; i < slots; i++) begin
        case ($urandom_range(0, 15))
          0: arr = 65535;
          1: arr = 0;
          default: arr = time_now() + $urandom_range(0, 12);
        endcase
        if (arr > 65535) arr = 65535;
        case ($urandom_range(0, 15))
          0: run = 0;
          1: run = $urandom_range(0, 255);
          default: run = $urandom_range(1, 6);
        endcase
        budget += (run == 0) ? 1 : run;
        load_entry(4'(i), 16'(arr), 8'(run), 3'($urandom_range(0, 7)));
      end
      if (budget > 90) budget = 90;
      if (items_sent >= HOLD_AFTER_ITEMS && !hold_done) begin
        long_hold = 1'b1;
        hold_done = 1'b1;
      end
      repeat (budget) begin
        if ($urandom_range(0, 11) == 0) begin
          if ($urandom_range(0, 1) == 0) begin
            noise_load();
          end else begin
            load_entry(4'($urandom_range(0, slots - 1)), time_now(),
                       8'($urandom_range(0, 4)), 3'($urandom_range(0, 7)));
          end
        end
        tick_once();
      end
    end

    // Final stretch without idling: one late task runs to completion and the
    // idle ticks after it are checked.
    idle_on = 1'b0;
    write_entries_in_use(5'd1);
    load_entry(4'd0, time_now() + 16'd5, 8'd20, 3'd2);
    repeat (FINAL_TICKS) tick_once();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending_count == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d items (%0d ticks); checked %0d tick results with %0d completions,",
             items_sent, ticks_sent, results_checked, completions);
    $display("%0d all-done reports, entries in use from 0 to 31 and a long output stall.",
             all_done_seen);
    if (fail_count == 0 && pending_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
